// ===== design/dodl_pkg.sv =====
package dodl_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_CAPACITY = 64;
  localparam int DEF_ID_BITS  = 32;

  // Fixed field widths of the request and result items.
  localparam int REQ_W    = 2;
  localparam int OBJ_ID_W = 32;
  localparam int KEY_W    = 32;
  localparam int TAG_W    = 32;
  localparam int RANK_W   = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Tag given to every insert made in multi-depth mode.
  localparam logic [TAG_W-1:0] MULTI_TAG = 32'd999999;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_READ   = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_RANK  = 2'd3
  } status_t;

  // What every cell of the chain does in the current cycle.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_CLOSE  = 2'd2
  } cell_op_t;

  // Sort part of one list entry: depth key first, creation tag second.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  // Command broadcast to all cells.
  typedef struct packed {
    cell_op_t op;
    logic     or_equal;
    entry_t   ent;
  } cell_cmd_t;

endpackage

// ===== design/dodl_if.sv =====
// Request channel: one item per list operation.
interface dodl_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [dodl_pkg::REQ_W-1:0]            req_type;
  logic [dodl_pkg::OBJ_ID_W-1:0]         object_id;
  logic signed [dodl_pkg::KEY_W-1:0]     depth_key;
  logic                                  multi_depth;
  logic [dodl_pkg::RANK_W-1:0]           rank;

  modport source (output valid, req_type, object_id, depth_key, multi_depth, rank,
                  input ready);
  modport sink   (input valid, req_type, object_id, depth_key, multi_depth, rank,
                  output ready);
endinterface

// Result channel: one item per request.
interface dodl_res_if;
  logic                                  valid;
  logic                                  ready;
  logic [dodl_pkg::STATUS_W-1:0]         status;
  logic [dodl_pkg::OBJ_ID_W-1:0]         entry_id;
  logic signed [dodl_pkg::KEY_W-1:0]     entry_depth;
  logic [dodl_pkg::TAG_W-1:0]            entry_tag;
  logic [dodl_pkg::COUNT_W-1:0]          entry_count;

  modport source (output valid, status, entry_id, entry_depth, entry_tag, entry_count,
                  input ready);
  modport sink   (input valid, status, entry_id, entry_depth, entry_tag, entry_count,
                  output ready);
endinterface

// ===== design/depth_ordered_draw_list_core.sv =====
// Channel   Dir  Handshake          Item
// in_req    in   valid/ready        req_type, object_id, depth_key, multi_depth, rank
// out_res   out  valid/ready        status, entry_id, entry_depth, entry_tag, entry_count
//
// Insert and read run their operation state and then emit; update does the same, or, when
// the key changes, first closes the old slot and then places it again through the cell chain.
// Remove deletes every matching entry, the chain closing one per cycle, then emits.
// Reset (rst_n low, synchronous) empties the list and clears the tag counter; no sweep.
// A result waiting on out_res does not stop the next item from being accepted,
// but a finished item is held until the output register is free.
module depth_ordered_draw_list_core #(
  parameter int CAPACITY = dodl_pkg::DEF_CAPACITY,
  parameter int ID_BITS  = dodl_pkg::DEF_ID_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  dodl_req_if.sink     in_req,
  dodl_res_if.source   out_res
);

  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int LVL     = $clog2(CAPACITY);
  localparam int WIDE_ID = (ID_BITS > dodl_pkg::OBJ_ID_W) ? ID_BITS : dodl_pkg::OBJ_ID_W;
  localparam int RC_W    = (CNT_W > dodl_pkg::RANK_W) ? CNT_W : dodl_pkg::RANK_W;
  localparam int CE_W    = (CNT_W > dodl_pkg::COUNT_W) ? CNT_W : dodl_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_REMOVE,
    S_UPD_FIND,
    S_UPD_PLACE,
    S_READ,
    S_EMIT
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [dodl_pkg::TAG_W-1:0]      counter_r, counter_nxt;
  logic [ID_BITS-1:0]              req_id_r, req_id_nxt;
  logic signed [dodl_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                            multi_r, multi_nxt;
  logic [dodl_pkg::RANK_W-1:0]     rank_r, rank_nxt;
  logic                            found_r, found_nxt;
  logic [dodl_pkg::TAG_W-1:0]      utag_r, utag_nxt;
  logic                            rose_r, rose_nxt;
  dodl_pkg::status_t               res_status_r, res_status_nxt;
  logic [dodl_pkg::OBJ_ID_W-1:0]   res_id_r, res_id_nxt;
  logic signed [dodl_pkg::KEY_W-1:0] res_depth_r, res_depth_nxt;
  logic [dodl_pkg::TAG_W-1:0]      res_tag_r, res_tag_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [dodl_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [dodl_pkg::OBJ_ID_W-1:0]   out_id_r, out_id_nxt;
  logic signed [dodl_pkg::KEY_W-1:0] out_depth_r, out_depth_nxt;
  logic [dodl_pkg::TAG_W-1:0]      out_tag_r, out_tag_nxt;
  logic [dodl_pkg::COUNT_W-1:0]    out_count_r, out_count_nxt;

  dodl_pkg::cell_cmd_t             cmd;
  dodl_pkg::entry_t                ent [CAPACITY];
  logic [ID_BITS-1:0]              ids [CAPACITY];
  logic [CAPACITY-1:0]             flag;
  logic [CAPACITY-1:0]             match;
  logic [CAPACITY-1:0]             valid;
  logic [CAPACITY-1:0]             pre [LVL+1];
  logic [CAPACITY-1:0]             first;
  logic                            any_match;
  dodl_pkg::entry_t                old_ent;
  logic [dodl_pkg::TAG_W-1:0]      ins_tag;
  logic [WIDE_ID-1:0]              in_id_wide;
  logic [WIDE_ID-1:0]              rd_id_wide;
  logic [RC_W-1:0]                 rank_wide;
  logic [RC_W-1:0]                 count_cmp;
  logic [IDX_W-1:0]                rd_idx;
  logic [CE_W-1:0]                 count_wide;
  logic                            out_free;
  logic                            in_ready;
  logic                            accept;

  // Slot occupancy follows from the fill count.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = CNT_W'(i) < count_r;
    end
  end

  // The chain of cells.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int LEFT  = (g == 0) ? 0 : g - 1;
    localparam int RIGHT = (g == CAPACITY - 1) ? g : g + 1;
    dodl_cell #(.ID_BITS(ID_BITS)) u_cell (
      .clk         (clk),
      .valid_i     (valid[g]),
      .cmd_i       (cmd),
      .cmd_id_i    (req_id_r),
      .left_flag_i ((g == 0) ? 1'b0 : flag[LEFT]),
      .left_ent_i  (ent[LEFT]),
      .left_id_i   (ids[LEFT]),
      .right_ent_i (ent[RIGHT]),
      .right_id_i  (ids[RIGHT]),
      .close_i     (pre[LVL][g]),
      .ent_o       (ent[g]),
      .id_o        (ids[g]),
      .flag_o      (flag[g]),
      .match_o     (match[g])
    );
  end

  // Prefix OR of the id matches in log steps: every cell at or behind the
  // first match closes up by one slot.
  always_comb begin
    pre[0] = match;
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
        end else begin
          pre[l+1][i] = pre[l][i];
        end
      end
    end
    any_match = |match;
    first     = match & ~{pre[LVL][CAPACITY-2:0], 1'b0};
  end

  // Entry at the first match, selected by its one-hot flag.
  always_comb begin
    old_ent = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      old_ent = dodl_pkg::entry_t'(old_ent | (first[i] ? ent[i] : '0));
    end
  end

  // Read port and width adjustments.
  always_comb begin
    in_id_wide = WIDE_ID'(in_req.object_id);
    rank_wide  = RC_W'(rank_r);
    count_cmp  = RC_W'(count_r);
    rd_idx     = rank_wide[IDX_W-1:0];
    rd_id_wide = WIDE_ID'(ids[rd_idx]);
    count_wide = CE_W'(count_r);
    ins_tag    = multi_r ? dodl_pkg::MULTI_TAG : counter_r + dodl_pkg::TAG_W'(1);
  end

  assign out_free = !out_valid_r || out_res.ready;
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_EMIT) && out_free);
  assign accept   = in_req.valid && in_ready;

  // Sequencer: broadcast commands to the chain and collect the result.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    counter_nxt    = counter_r;
    req_id_nxt     = req_id_r;
    key_nxt        = key_r;
    multi_nxt      = multi_r;
    rank_nxt       = rank_r;
    found_nxt      = found_r;
    utag_nxt       = utag_r;
    rose_nxt       = rose_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_depth_nxt  = res_depth_r;
    res_tag_nxt    = res_tag_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_depth_nxt  = out_depth_r;
    out_tag_nxt    = out_tag_r;
    out_count_nxt  = out_count_r;
    cmd.op         = dodl_pkg::CELL_HOLD;
    cmd.or_equal   = 1'b0;
    cmd.ent.key    = key_r;
    cmd.ent.tag    = utag_r;

    case (state_r)
      S_INSERT: begin
        if (count_r >= CNT_W'(CAPACITY)) begin
          res_status_nxt = dodl_pkg::ST_FULL;
        end else begin
          cmd.op      = dodl_pkg::CELL_INSERT;
          cmd.ent.tag = ins_tag;
          count_nxt   = count_r + CNT_W'(1);
          if (!multi_r) begin
            counter_nxt = ins_tag;
          end
        end
        state_nxt = S_EMIT;
      end
      S_REMOVE: begin
        // One matching entry leaves the list per cycle.
        if (any_match) begin
          cmd.op    = dodl_pkg::CELL_CLOSE;
          count_nxt = count_r - CNT_W'(1);
          found_nxt = 1'b1;
        end else begin
          res_status_nxt = found_r ? dodl_pkg::ST_OK : dodl_pkg::ST_NOT_FOUND;
          state_nxt      = S_EMIT;
        end
      end
      S_UPD_FIND: begin
        if (!any_match) begin
          res_status_nxt = dodl_pkg::ST_NOT_FOUND;
          state_nxt      = S_EMIT;
        end else if (old_ent.key == key_r) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = dodl_pkg::CELL_CLOSE;
          count_nxt = count_r - CNT_W'(1);
          utag_nxt  = old_ent.tag;
          rose_nxt  = $signed(key_r) > $signed(old_ent.key);
          state_nxt = S_UPD_PLACE;
        end
      end
      S_UPD_PLACE: begin
        // A raised key goes first among equals, a lowered key last.
        cmd.op       = dodl_pkg::CELL_INSERT;
        cmd.or_equal = rose_r;
        count_nxt    = count_r + CNT_W'(1);
        state_nxt    = S_EMIT;
      end
      S_READ: begin
        if (rank_wide >= count_cmp) begin
          res_status_nxt = dodl_pkg::ST_BAD_RANK;
        end else begin
          res_id_nxt    = rd_id_wide[dodl_pkg::OBJ_ID_W-1:0];
          res_depth_nxt = ent[rd_idx].key;
          res_tag_nxt   = ent[rd_idx].tag;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_depth_nxt  = res_depth_r;
          out_tag_nxt    = res_tag_r;
          out_count_nxt  = count_wide[dodl_pkg::COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = state_r;
      end
    endcase

    // Take a new item and start its operation.
    if (accept) begin
      req_id_nxt     = in_id_wide[ID_BITS-1:0];
      key_nxt        = in_req.depth_key;
      multi_nxt      = in_req.multi_depth;
      rank_nxt       = in_req.rank;
      found_nxt      = 1'b0;
      res_status_nxt = dodl_pkg::ST_OK;
      res_id_nxt     = '0;
      res_depth_nxt  = '0;
      res_tag_nxt    = '0;
      case (dodl_pkg::req_type_t'(in_req.req_type))
        dodl_pkg::REQ_INSERT: state_nxt = S_INSERT;
        dodl_pkg::REQ_REMOVE: state_nxt = S_REMOVE;
        dodl_pkg::REQ_UPDATE: state_nxt = S_UPD_FIND;
        default:              state_nxt = S_READ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      counter_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      counter_r   <= counter_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_id_r     <= req_id_nxt;
    key_r        <= key_nxt;
    multi_r      <= multi_nxt;
    rank_r       <= rank_nxt;
    found_r      <= found_nxt;
    utag_r       <= utag_nxt;
    rose_r       <= rose_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_depth_r  <= res_depth_nxt;
    res_tag_r    <= res_tag_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_depth_r  <= out_depth_nxt;
    out_tag_r    <= out_tag_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_req.ready        = in_ready;
  assign out_res.valid       = out_valid_r;
  assign out_res.status      = out_status_r;
  assign out_res.entry_id    = out_id_r;
  assign out_res.entry_depth = out_depth_r;
  assign out_res.entry_tag   = out_tag_r;
  assign out_res.entry_count = out_count_r;

endmodule

// ===== design/dodl_cell.sv =====
// One slot of the sorted list. It compares its entry against the broadcast
// entry and, on an insert or a close, takes data from its left or right neighbor.
module dodl_cell #(
  parameter int ID_BITS = dodl_pkg::DEF_ID_BITS
) (
  input  logic                 clk,
  input  logic                 valid_i,
  input  dodl_pkg::cell_cmd_t  cmd_i,
  input  logic [ID_BITS-1:0]   cmd_id_i,
  input  logic                 left_flag_i,
  input  dodl_pkg::entry_t     left_ent_i,
  input  logic [ID_BITS-1:0]   left_id_i,
  input  dodl_pkg::entry_t     right_ent_i,
  input  logic [ID_BITS-1:0]   right_id_i,
  input  logic                 close_i,
  output dodl_pkg::entry_t     ent_o,
  output logic [ID_BITS-1:0]   id_o,
  output logic                 flag_o,
  output logic                 match_o
);

  dodl_pkg::entry_t    ent_r, ent_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic                after_new;
  logic                same_new;

  // Ordering of the held entry against the broadcast entry.
  always_comb begin
    if (ent_r.key != cmd_i.ent.key) begin
      after_new = $signed(ent_r.key) > $signed(cmd_i.ent.key);
    end else begin
      after_new = ent_r.tag > cmd_i.ent.tag;
    end
    same_new = (ent_r.key == cmd_i.ent.key) && (ent_r.tag == cmd_i.ent.tag);
    // An empty slot counts as after anything, so the flags rise once along the chain.
    flag_o   = !valid_i || after_new || (cmd_i.or_equal && same_new);
    match_o  = valid_i && (id_r == cmd_id_i);
  end

  // Shift right behind the insert point, or left behind the removed slot.
  always_comb begin
    ent_nxt = ent_r;
    id_nxt  = id_r;
    case (cmd_i.op)
      dodl_pkg::CELL_INSERT: begin
        if (left_flag_i) begin
          ent_nxt = left_ent_i;
          id_nxt  = left_id_i;
        end else if (flag_o) begin
          ent_nxt = cmd_i.ent;
          id_nxt  = cmd_id_i;
        end
      end
      dodl_pkg::CELL_CLOSE: begin
        if (close_i) begin
          ent_nxt = right_ent_i;
          id_nxt  = right_id_i;
        end
      end
      default: begin
        ent_nxt = ent_r;
        id_nxt  = id_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    id_r  <= id_nxt;
  end

  assign ent_o = ent_r;
  assign id_o  = id_r;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int LIST_CAP     = dodl_pkg::DEF_CAPACITY;
  localparam int IDLE_PCT     = 28;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 1000000;

  // One request as offered on the input channel.
  typedef struct {
    dodl_pkg::req_type_t                 kind;
    logic [dodl_pkg::OBJ_ID_W-1:0]       id;
    logic signed [dodl_pkg::KEY_W-1:0]   key;
    logic                                multi;
    logic [dodl_pkg::RANK_W-1:0]         rank;
  } draw_req_t;

  // One result as it should appear on the output channel.
  typedef struct {
    dodl_pkg::status_t                   status;
    logic [dodl_pkg::OBJ_ID_W-1:0]       id;
    logic signed [dodl_pkg::KEY_W-1:0]   depth;
    logic [dodl_pkg::TAG_W-1:0]          tag;
    logic [dodl_pkg::COUNT_W-1:0]        count;
  } draw_result_t;

  logic clk = 1'b0;
  logic rst_n;

  dodl_req_if req_if ();
  dodl_res_if res_if ();

  depth_ordered_draw_list_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_res (res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the sorted list.
  logic signed [dodl_pkg::KEY_W-1:0] list_key [LIST_CAP];
  logic [dodl_pkg::TAG_W-1:0]        list_tag [LIST_CAP];
  logic [dodl_pkg::OBJ_ID_W-1:0]     list_id  [LIST_CAP];
  int                                list_count  = 0;
  logic [dodl_pkg::TAG_W-1:0]        tag_counter = '0;

  draw_result_t pending_draw_results [$];

  int mismatch_count  = 0;
  int results_checked = 0;
  int kind_seen   [4] = '{default: 0};
  int status_seen [4] = '{default: 0};
  int peak_count      = 0;
  int cycle_count     = 0;

  bit no_idle          = 1'b0;
  int hold_off_request = 0;
  int hold_left        = 0;

  // True when the first pair sorts strictly after the second.
  function automatic logic sorts_after(logic signed [dodl_pkg::KEY_W-1:0] ka,
                                       logic [dodl_pkg::TAG_W-1:0] ta,
                                       logic signed [dodl_pkg::KEY_W-1:0] kb,
                                       logic [dodl_pkg::TAG_W-1:0] tb);
    if (ka != kb) return ka > kb;
    return ta > tb;
  endfunction

  // First slot that sorts after the pair, or also equal to it when or_equal is set.
  function automatic int place_index(logic signed [dodl_pkg::KEY_W-1:0] k,
                                     logic [dodl_pkg::TAG_W-1:0] t, logic or_equal);
    int i;
    for (i = 0; i < list_count; i++) begin
      if (sorts_after(list_key[i], list_tag[i], k, t) ||
          (or_equal && list_key[i] == k && list_tag[i] == t))
        break;
    end
    return i;
  endfunction

  function automatic void shift_in(int pos, logic signed [dodl_pkg::KEY_W-1:0] k,
                                   logic [dodl_pkg::TAG_W-1:0] t,
                                   logic [dodl_pkg::OBJ_ID_W-1:0] id);
    for (int i = list_count; i > pos; i--) begin
      list_key[i] = list_key[i-1];
      list_tag[i] = list_tag[i-1];
      list_id[i]  = list_id[i-1];
    end
    list_key[pos] = k;
    list_tag[pos] = t;
    list_id[pos]  = id;
    list_count++;
  endfunction

  function automatic void shift_out(int pos);
    for (int i = pos; i + 1 < list_count; i++) begin
      list_key[i] = list_key[i+1];
      list_tag[i] = list_tag[i+1];
      list_id[i]  = list_id[i+1];
    end
    list_count--;
  endfunction

  // Applies one accepted request to the shadow list and returns its result.
  function automatic draw_result_t apply_list_request(draw_req_t r);
    draw_result_t res;
    int           i;
    logic [dodl_pkg::TAG_W-1:0] t;
    logic         rose;
    logic         found;
    res = '{status: dodl_pkg::ST_OK, id: '0, depth: '0, tag: '0, count: '0};
    case (r.kind)
      dodl_pkg::REQ_INSERT: begin
        if (list_count >= LIST_CAP) begin
          res.status = dodl_pkg::ST_FULL;
        end else begin
          if (r.multi) begin
            t = dodl_pkg::MULTI_TAG;
          end else begin
            tag_counter = tag_counter + dodl_pkg::TAG_W'(1);
            t = tag_counter;
          end
          shift_in(place_index(r.key, t, 1'b0), r.key, t, r.id);
        end
      end
      dodl_pkg::REQ_REMOVE: begin
        found = 1'b0;
        i = 0;
        while (i < list_count) begin
          if (list_id[i] == r.id) begin
            shift_out(i);
            found = 1'b1;
          end else begin
            i++;
          end
        end
        if (!found) res.status = dodl_pkg::ST_NOT_FOUND;
      end
      dodl_pkg::REQ_UPDATE: begin
        for (i = 0; i < list_count; i++) begin
          if (list_id[i] == r.id) break;
        end
        if (i >= list_count) begin
          res.status = dodl_pkg::ST_NOT_FOUND;
        end else if (list_key[i] != r.key) begin
          // A raised key goes ahead of equal entries, a lowered one behind them.
          rose = r.key > list_key[i];
          t = list_tag[i];
          shift_out(i);
          shift_in(place_index(r.key, t, rose), r.key, t, r.id);
        end
      end
      default: begin
        if (r.rank >= list_count) begin
          res.status = dodl_pkg::ST_BAD_RANK;
        end else begin
          res.id    = list_id[r.rank];
          res.depth = list_key[r.rank];
          res.tag   = list_tag[r.rank];
        end
      end
    endcase
    res.count = list_count[dodl_pkg::COUNT_W-1:0];
    kind_seen[r.kind]++;
    status_seen[res.status]++;
    if (list_count > peak_count) peak_count = list_count;
    return res;
  endfunction

  // Offers one item, with random gaps first, and records its result once accepted.
  task automatic send_req(dodl_pkg::req_type_t kind, logic [dodl_pkg::OBJ_ID_W-1:0] id,
                          logic signed [dodl_pkg::KEY_W-1:0] key, logic multi,
                          logic [dodl_pkg::RANK_W-1:0] rank);
    draw_req_t    r;
    draw_result_t want;
    r = '{kind: kind, id: id, key: key, multi: multi, rank: rank};
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= r.kind;
    req_if.object_id   <= r.id;
    req_if.depth_key   <= r.key;
    req_if.multi_depth <= r.multi;
    req_if.rank        <= r.rank;
    do @(posedge clk); while (!req_if.ready);
    want = apply_list_request(r);
    pending_draw_results.insert(pending_draw_results.size(), want);
  endtask

  // Ids mostly hit held entries or a small pool, so duplicates and hits are common.
  function automatic logic [dodl_pkg::OBJ_ID_W-1:0] pick_id();
    int p;
    p = $urandom_range(99);
    if (p < 40 && list_count > 0) return list_id[$urandom_range(list_count - 1)];
    if (p < 75) return $urandom_range(20, 1);
    return $urandom;
  endfunction

  // Keys cluster around zero for ties, with extremes and full-range values mixed in.
  function automatic logic signed [dodl_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0, 1: return int'($urandom_range(6)) - 3;
      2: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sh8000_0001;
          default: return 32'sh7FFF_FFFE;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [dodl_pkg::RANK_W-1:0] pick_rank();
    if (list_count > 0 && $urandom_range(99) < 75)
      return dodl_pkg::RANK_W'($urandom_range(list_count - 1));
    return dodl_pkg::RANK_W'($urandom_range(63));
  endfunction

  task automatic send_random(int ins_pct, int rem_pct, int upd_pct);
    int                  roll;
    dodl_pkg::req_type_t kind;
    roll = $urandom_range(99);
    if (roll < ins_pct) kind = dodl_pkg::REQ_INSERT;
    else if (roll < ins_pct + rem_pct) kind = dodl_pkg::REQ_REMOVE;
    else if (roll < ins_pct + rem_pct + upd_pct) kind = dodl_pkg::REQ_UPDATE;
    else kind = dodl_pkg::REQ_READ;
    send_req(kind, pick_id(), pick_key(), $urandom_range(99) < 30, pick_rank());
  endtask

  // Requests against an empty list.
  task automatic test_empty_list();
    send_req(dodl_pkg::REQ_READ, '0, '0, 1'b0, 6'd0);
    send_req(dodl_pkg::REQ_READ, '1, '1, 1'b1, 6'd63);
    send_req(dodl_pkg::REQ_REMOVE, 32'h0000_1234, '0, 1'b0, 6'd0);
    send_req(dodl_pkg::REQ_UPDATE, 32'h0000_1234, 32'sd5, 1'b0, 6'd0);
  endtask

  // Extreme ids and keys, both tag sources.
  task automatic test_key_extremes();
    send_req(dodl_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 6'd0);
    send_req(dodl_pkg::REQ_INSERT, 32'h0000_0000, 32'sh8000_0000, 1'b0, 6'd0);
    send_req(dodl_pkg::REQ_INSERT, 32'hA5A5_A5A5, 32'sd0, 1'b1, 6'd0);
    send_req(dodl_pkg::REQ_INSERT, 32'h5A5A_5A5A, -32'sd1, 1'b0, 6'd0);
    send_req(dodl_pkg::REQ_READ, '0, '0, 1'b0, 6'd0);
    send_req(dodl_pkg::REQ_READ, '0, '0, 1'b0, 6'd3);
    send_req(dodl_pkg::REQ_UPDATE, 32'h0000_0000, 32'sh7FFF_FFFF, 1'b0, 6'd0);
    send_req(dodl_pkg::REQ_REMOVE, 32'hFFFF_FFFF, '0, 1'b0, 6'd0);
    send_req(dodl_pkg::REQ_REMOVE, 32'h0000_0000, '0, 1'b0, 6'd0);
  endtask

  // Equal keys and tags, updates that raise, lower or keep a key, duplicate ids.
  task automatic test_ties_and_updates();
    send_req(dodl_pkg::REQ_INSERT, 32'd1, 32'sd5, 1'b1, 6'd0);
    send_req(dodl_pkg::REQ_INSERT, 32'd2, 32'sd5, 1'b1, 6'd0);
    send_req(dodl_pkg::REQ_INSERT, 32'd3, 32'sd5, 1'b1, 6'd0);
    send_req(dodl_pkg::REQ_INSERT, 32'd4, 32'sd9, 1'b1, 6'd0);
    send_req(dodl_pkg::REQ_UPDATE, 32'd1, 32'sd9, 1'b0, 6'd0);
    send_req(dodl_pkg::REQ_UPDATE, 32'd3, 32'sd5, 1'b0, 6'd0);
    send_req(dodl_pkg::REQ_INSERT, 32'd5, -32'sd7, 1'b1, 6'd0);
    send_req(dodl_pkg::REQ_UPDATE, 32'd2, -32'sd7, 1'b0, 6'd0);
    send_req(dodl_pkg::REQ_INSERT, 32'd3, 32'sd5, 1'b0, 6'd0);
    send_req(dodl_pkg::REQ_REMOVE, 32'd3, '0, 1'b0, 6'd0);
    for (int r = 0; r < list_count; r++)
      send_req(dodl_pkg::REQ_READ, '0, '0, 1'b0, r[dodl_pkg::RANK_W-1:0]);
  endtask

  // Fill to capacity, bounce off it, then drain the list.
  task automatic test_full_list();
    while (list_count < LIST_CAP) send_req(dodl_pkg::REQ_INSERT, pick_id(), pick_key(),
                                           $urandom_range(99) < 30, pick_rank());
    send_req(dodl_pkg::REQ_INSERT, 32'hDEAD_BEEF, 32'sd0, 1'b0, 6'd0);
    send_req(dodl_pkg::REQ_INSERT, 32'hDEAD_BEEF, 32'sd0, 1'b1, 6'd0);
    send_req(dodl_pkg::REQ_READ, '0, '0, 1'b0, 6'd63);
    send_req(dodl_pkg::REQ_REMOVE, list_id[0], '0, 1'b0, 6'd0);
    // The counter must not have moved on the refused inserts.
    send_req(dodl_pkg::REQ_INSERT, 32'hDEAD_BEEF, 32'sd1, 1'b0, 6'd0);
    send_req(dodl_pkg::REQ_READ, '0, '0, 1'b0, pick_rank());
    while (list_count > 0) send_req(dodl_pkg::REQ_REMOVE,
                                    list_id[$urandom_range(list_count - 1)],
                                    pick_key(), 1'($urandom_range(1)), pick_rank());
  endtask

  // Alternating growth and shrink phases keep the list moving over its whole range.
  task automatic test_random_traffic(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if ((i / 150) % 2 == 0) send_random(55, 10, 15);
      else send_random(12, 38, 20);
    end
  endtask

  task automatic test_no_idle(int n_items);
    no_idle = 1'b1;
    for (int i = 0; i < n_items; i++) send_random(35, 15, 25);
    no_idle = 1'b0;
  endtask

  // The receiver stops for a long stretch while items keep coming.
  task automatic test_backpressure(int n_items);
    hold_off_request = 300;
    for (int i = 0; i < n_items; i++) send_random(40, 10, 20);
  endtask

  task automatic flag_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every accepted result with the oldest expected one.
  always @(posedge clk) begin : result_check
    draw_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_draw_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                 $time, res_if.status, res_if.entry_count);
        mismatch_count++;
      end else begin
        want = pending_draw_results.pop_front();
        results_checked++;
        flag_field("status", 32'(want.status), 32'(res_if.status));
        flag_field("entry_id", want.id, res_if.entry_id);
        flag_field("entry_depth", want.depth, res_if.entry_depth);
        flag_field("entry_tag", want.tag, res_if.entry_tag);
        flag_field("entry_count", 32'(want.count), 32'(res_if.entry_count));
      end
    end
  end

  // Result-side readiness, with a counted hold-off on request.
  always @(posedge clk) begin : result_ready
    if (hold_off_request > 0) begin
      hold_left = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.req_type    = dodl_pkg::REQ_INSERT;
    req_if.object_id   = '0;
    req_if.depth_key   = '0;
    req_if.multi_depth = 1'b0;
    req_if.rank        = '0;
    res_if.ready       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_key_extremes();
    test_ties_and_updates();
    test_full_list();
    test_random_traffic(1000);
    test_no_idle(100);
    test_backpressure(30);
    req_if.valid <= 1'b0;

    // Let every outstanding result arrive, then watch for stray ones.
    while (pending_draw_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d inserts, %0d removes, %0d updates, %0d reads; list peaked at %0d.",
             kind_seen[dodl_pkg::REQ_INSERT], kind_seen[dodl_pkg::REQ_REMOVE],
             kind_seen[dodl_pkg::REQ_UPDATE], kind_seen[dodl_pkg::REQ_READ], peak_count);
    $display("Checked %0d results: %0d refused as full, %0d ids missing, %0d bad ranks.",
             results_checked, status_seen[dodl_pkg::ST_FULL],
             status_seen[dodl_pkg::ST_NOT_FOUND], status_seen[dodl_pkg::ST_BAD_RANK]);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/dodl_pkg.sv
design/dodl_if.sv
design/dodl_cell.sv
design/depth_ordered_draw_list_core.sv
tb/testbench.sv
